### rtl/gss_pkg.sv
// Shared types, constants and codes for the global SSIM score core.
// Used by gss_alu and global_ssim_score_core; depends on nothing.
package gss_pkg;

   localparam int PIXEL_COUNT_BITS_DEFAULT = 20;
   localparam int PIXEL_BITS     = 8;
   localparam int CFG_BITS       = 16;
   localparam int SSIM_BITS      = 18;
   localparam int TOTAL_BITS     = 21;
   localparam int STATUS_BITS    = 2;
   localparam int CSR_INDEX_BITS = 1;

   localparam logic [CFG_BITS-1:0] C1_RESET = 16'd1665;
   localparam logic [CFG_BITS-1:0] C2_RESET = 16'd14982;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_C1 = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_C2 = 1'd1;

   localparam logic [STATUS_BITS-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_FEW      = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_OVERFLOW = 2'd2;

   localparam int A_SHIFT      = 9;
   localparam int VAR_SHIFT    = 8;
   localparam int NUM_SHIFT    = 17;
   localparam int DEN_SHIFT    = 18;
   localparam int DIV_STEPS    = 19;
   localparam int DIV_CNT_BITS = $clog2(DIV_STEPS + 1);

   localparam logic [SSIM_BITS-1:0] SSIM_ONE = 18'h10000;

   typedef struct packed {
      logic [PIXEL_BITS-1:0] ref_pixel;
      logic [PIXEL_BITS-1:0] test_pixel;
      logic                  last_pixel;
   } gss_req_type;

   typedef struct packed {
      logic signed [SSIM_BITS-1:0] ssim_q16;
      logic [TOTAL_BITS-1:0]       pixel_total;
      logic [STATUS_BITS-1:0]      status;
   } gss_rsp_type;

   typedef enum logic [1:0] {
      GSS_IDLE,
      GSS_ISSUE,
      GSS_WAIT
   } gss_state_type;

   typedef enum logic [3:0] {
      ST_SXSY,
      ST_NN,
      ST_K1,
      ST_K2,
      ST_SXX,
      ST_SYY,
      ST_NV,
      ST_NXY,
      ST_DEN,
      ST_NUM,
      ST_DIV
   } gss_step_type;

   typedef enum logic [0:0] {
      GSS_ALU_MUL,
      GSS_ALU_DIV
   } gss_alu_op_type;

   typedef struct packed {
      logic           start;
      gss_alu_op_type op;
   } gss_alu_cmd_type;

   function automatic gss_step_type gss_next_step(input gss_step_type s);
      gss_step_type n;
      case (s)
         ST_SXSY: n = ST_NN;
         ST_NN:   n = ST_K1;
         ST_K1:   n = ST_K2;
         ST_K2:   n = ST_SXX;
         ST_SXX:  n = ST_SYY;
         ST_SYY:  n = ST_NV;
         ST_NV:   n = ST_NXY;
         ST_NXY:  n = ST_DEN;
         ST_DEN:  n = ST_NUM;
         ST_NUM:  n = ST_DIV;
         default: n = ST_SXSY;
      endcase
      return n;
   endfunction

endpackage

### rtl/gss_alu.sv
// Shared shift-add multiplier and restoring divider with one wide adder.
// Depends on gss_pkg for the command struct, op codes and divide step count.
module gss_alu #(
   parameter int OW = 66,
   parameter int FW = 150
) (
   input  logic                               clock,
   input  logic                               reset,
   input  gss_pkg::gss_alu_cmd_type           cmd,
   input  logic [FW-1:0]                      opa,
   input  logic [OW-1:0]                      opb,
   output logic                               done,
   output logic [FW-1:0]                      acc,
   output logic [gss_pkg::DIV_STEPS-1:0]      quo
);

   logic                                run_ff, run_in;
   logic                                done_ff, done_in;
   gss_pkg::gss_alu_op_type             op_ff, op_in;
   logic [FW-1:0]                       acc_ff, acc_in;
   logic [FW-1:0]                       sh_ff, sh_in;
   logic [OW-1:0]                       mp_ff, mp_in;
   logic [gss_pkg::DIV_CNT_BITS-1:0]    cnt_ff, cnt_in;
   logic [gss_pkg::DIV_STEPS-1:0]       quo_ff, quo_in;
   logic                                sub;
   logic [FW:0]                         add_res;

   assign sub     = (op_ff == gss_pkg::GSS_ALU_DIV);
   assign add_res = {1'b0, acc_ff} + {1'b0, (sub ? ~sh_ff : sh_ff)} + (FW+1)'(sub);

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      acc_in  = acc_ff;
      sh_in   = sh_ff;
      mp_in   = mp_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      if (cmd.start) begin
         run_in = 1'b1;
         op_in  = cmd.op;
         sh_in  = opa;
         case (cmd.op)
            gss_pkg::GSS_ALU_MUL: begin
               acc_in = '0;
               mp_in  = opb;
            end
            gss_pkg::GSS_ALU_DIV: begin
               cnt_in = gss_pkg::DIV_CNT_BITS'(gss_pkg::DIV_STEPS);
               quo_in = '0;
            end
            default: run_in = 1'b0;
         endcase
      end else if (run_ff) begin
         case (op_ff)
            gss_pkg::GSS_ALU_MUL: begin
               if (mp_ff[0]) begin
                  acc_in = add_res[FW-1:0];
               end
               sh_in = sh_ff << 1;
               mp_in = mp_ff >> 1;
               if (mp_ff[OW-1:1] == '0) begin
                  run_in  = 1'b0;
                  done_in = 1'b1;
               end
            end
            gss_pkg::GSS_ALU_DIV: begin
               if (add_res[FW]) begin
                  acc_in = add_res[FW-1:0];
               end
               quo_in = {quo_ff[gss_pkg::DIV_STEPS-2:0], add_res[FW]};
               sh_in  = sh_ff >> 1;
               cnt_in = cnt_ff - gss_pkg::DIV_CNT_BITS'(1);
               if (cnt_ff == gss_pkg::DIV_CNT_BITS'(1)) begin
                  run_in  = 1'b0;
                  done_in = 1'b1;
               end
            end
            default: run_in = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      op_ff  <= op_in;
      acc_ff <= acc_in;
      sh_ff  <= sh_in;
      mp_ff  <= mp_in;
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
   end

   assign done = done_ff;
   assign acc  = acc_ff;
   assign quo  = quo_ff;

endmodule

### rtl/global_ssim_score_core.sv
// Global SSIM score core: accumulates one pixel pair per cycle while busy is low, then
// scores the image. On the last pair of a scored image the score is computed on the
// shared bit-serial multiply/divide unit, and busy stays high meanwhile.
// Short or overflowed images report in the cycle after the last pair with no busy
// time. Results cannot be stalled.
// Synchronous reset clears accumulators and restores c1_q8 = 1665, c2_q8 = 14982.
module global_ssim_score_core #(
   parameter int PIXEL_COUNT_BITS = gss_pkg::PIXEL_COUNT_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  gss_pkg::gss_req_type                req_data,
   output logic                                rsp_strobe,
   output gss_pkg::gss_rsp_type                rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [gss_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [gss_pkg::CFG_BITS-1:0]        csr_data
);

   localparam int CW = PIXEL_COUNT_BITS + 1;
   localparam int SW = PIXEL_COUNT_BITS + 8;
   localparam int QW = PIXEL_COUNT_BITS + 16;
   localparam int OW = 2 * SW + 10;
   localparam int PW = 2 * OW;
   localparam int FW = PW + gss_pkg::DEN_SHIFT;
   localparam int TW = (CW > gss_pkg::TOTAL_BITS) ? CW : gss_pkg::TOTAL_BITS;

   gss_pkg::gss_state_type              state_ff, state_in;
   gss_pkg::gss_step_type               step_ff, step_in;
   logic [CW-1:0]                       cnt_ff, cnt_in;
   logic [SW-1:0]                       rsum_ff, rsum_in, tsum_ff, tsum_in;
   logic [QW-1:0]                       rsq_ff, rsq_in, tsq_ff, tsq_in, xsum_ff, xsum_in;
   logic                                ovf_ff, ovf_in;
   logic [gss_pkg::CFG_BITS-1:0]        c1_ff, c1_in, c2_ff, c2_in;
   logic [QW:0]                         sv_ff, sv_in;
   logic [OW-1:0]                       p_ff, p_in, t_ff, t_in, k1_ff, k1_in, k2_ff, k2_in;
   logic [OW-1:0]                       aa_ff, aa_in, sq_ff, sq_in, v_ff, v_in;
   logic [OW-1:0]                       bb_ff, bb_in, dd_ff, dd_in;
   logic [OW-1:0]                       dmag_ff, dmag_in, kmag_ff, kmag_in;
   logic                                dneg_ff, dneg_in, neg_ff, neg_in;
   logic [PW-1:0]                       den_ff, den_in;
   logic                                rsp_strobe_ff, rsp_strobe_in;
   gss_pkg::gss_rsp_type                rsp_ff, rsp_in;

   gss_pkg::gss_alu_cmd_type            alu_cmd;
   logic [FW-1:0]                       alu_opa;
   logic [OW-1:0]                       alu_opb;
   logic                                alu_done;
   logic [FW-1:0]                       alu_acc;
   logic [gss_pkg::DIV_STEPS-1:0]       alu_quo;

   logic                                accept;
   logic                                full;
   logic                                ovf_new;
   logic [CW-1:0]                       cnt_new;
   logic [15:0]                         xx, yy, xy;
   logic [TW-1:0]                       total_wide;
   logic [OW-1:0]                       prod_lo;
   logic [OW:0]                         pxy_diff;
   logic [OW-1:0]                       t9;
   logic [gss_pkg::DIV_STEPS-1:0]       q_round;
   logic                                den_zero;
   logic [gss_pkg::SSIM_BITS-1:0]       mag;
   logic [gss_pkg::SSIM_BITS-1:0]       ssim_val;

   gss_alu #(
      .OW(OW),
      .FW(FW)
   ) u_alu (
      .clock (clock),
      .reset (reset),
      .cmd   (alu_cmd),
      .opa   (alu_opa),
      .opb   (alu_opb),
      .done  (alu_done),
      .acc   (alu_acc),
      .quo   (alu_quo)
   );

   assign busy       = (state_ff != gss_pkg::GSS_IDLE);
   assign accept     = start && !busy;
   assign full       = cnt_ff[PIXEL_COUNT_BITS];
   assign ovf_new    = ovf_ff | full;
   assign cnt_new    = full ? cnt_ff : cnt_ff + CW'(1);
   assign xx         = 16'(req_data.ref_pixel) * 16'(req_data.ref_pixel);
   assign yy         = 16'(req_data.test_pixel) * 16'(req_data.test_pixel);
   assign xy         = 16'(req_data.ref_pixel) * 16'(req_data.test_pixel);
   assign total_wide = TW'(cnt_new);

   assign prod_lo  = alu_acc[OW-1:0];
   assign pxy_diff = {1'b0, prod_lo} - {1'b0, p_ff};
   assign t9       = dmag_ff << gss_pkg::A_SHIFT;
   assign q_round  = (alu_quo + gss_pkg::DIV_STEPS'(1)) >> 1;
   assign den_zero = (den_ff == '0);
   assign mag      = (den_zero || q_round > gss_pkg::DIV_STEPS'(gss_pkg::SSIM_ONE))
                   ? gss_pkg::SSIM_ONE : gss_pkg::SSIM_BITS'(q_round);
   assign ssim_val = (neg_ff && !den_zero) ? -mag : mag;

   assign csr_ready = !busy;

   // operand select for the shared unit
   always_comb begin
      alu_cmd.start = (state_ff == gss_pkg::GSS_ISSUE);
      alu_cmd.op    = gss_pkg::GSS_ALU_MUL;
      alu_opa       = '0;
      alu_opb       = '0;
      case (step_ff)
         gss_pkg::ST_SXSY: begin
            alu_opa = FW'(rsum_ff);
            alu_opb = OW'(tsum_ff);
         end
         gss_pkg::ST_NN: begin
            alu_opa = FW'(cnt_ff);
            alu_opb = OW'(cnt_ff);
         end
         gss_pkg::ST_K1: begin
            alu_opa = FW'(t_ff);
            alu_opb = OW'(c1_ff);
         end
         gss_pkg::ST_K2: begin
            alu_opa = FW'(t_ff);
            alu_opb = OW'(c2_ff);
         end
         gss_pkg::ST_SXX: begin
            alu_opa = FW'(rsum_ff);
            alu_opb = OW'(rsum_ff);
         end
         gss_pkg::ST_SYY: begin
            alu_opa = FW'(tsum_ff);
            alu_opb = OW'(tsum_ff);
         end
         gss_pkg::ST_NV: begin
            alu_opa = FW'(sv_ff);
            alu_opb = OW'(cnt_ff);
         end
         gss_pkg::ST_NXY: begin
            alu_opa = FW'(xsum_ff);
            alu_opb = OW'(cnt_ff);
         end
         gss_pkg::ST_DEN: begin
            alu_opa = FW'(bb_ff);
            alu_opb = dd_ff;
         end
         gss_pkg::ST_NUM: begin
            alu_opa = FW'(aa_ff) << gss_pkg::NUM_SHIFT;
            alu_opb = kmag_ff;
         end
         gss_pkg::ST_DIV: begin
            alu_cmd.op = gss_pkg::GSS_ALU_DIV;
            alu_opa    = FW'(den_ff) << gss_pkg::DEN_SHIFT;
         end
         default: ;
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      cnt_in        = cnt_ff;
      rsum_in       = rsum_ff;
      tsum_in       = tsum_ff;
      rsq_in        = rsq_ff;
      tsq_in        = tsq_ff;
      xsum_in       = xsum_ff;
      ovf_in        = ovf_ff;
      c1_in         = c1_ff;
      c2_in         = c2_ff;
      sv_in         = sv_ff;
      p_in          = p_ff;
      t_in          = t_ff;
      k1_in         = k1_ff;
      k2_in         = k2_ff;
      aa_in         = aa_ff;
      sq_in         = sq_ff;
      v_in          = v_ff;
      bb_in         = bb_ff;
      dd_in         = dd_ff;
      dmag_in       = dmag_ff;
      dneg_in       = dneg_ff;
      kmag_in       = kmag_ff;
      neg_in        = neg_ff;
      den_in        = den_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            gss_pkg::CSR_C1: c1_in = csr_data;
            gss_pkg::CSR_C2: c2_in = csr_data;
            default: ;
         endcase
      end

      case (state_ff)
         gss_pkg::GSS_IDLE: begin
            if (accept) begin
               if (!full) begin
                  cnt_in  = cnt_ff + CW'(1);
                  rsum_in = rsum_ff + SW'(req_data.ref_pixel);
                  tsum_in = tsum_ff + SW'(req_data.test_pixel);
                  rsq_in  = rsq_ff + QW'(xx);
                  tsq_in  = tsq_ff + QW'(yy);
                  xsum_in = xsum_ff + QW'(xy);
               end
               ovf_in = ovf_new;
               if (req_data.last_pixel) begin
                  rsp_in.pixel_total = total_wide[gss_pkg::TOTAL_BITS-1:0];
                  rsp_in.ssim_q16    = '0;
                  if (ovf_new || cnt_new < CW'(2)) begin
                     rsp_strobe_in = 1'b1;
                     rsp_in.status = ovf_new ? gss_pkg::STATUS_OVERFLOW
                                             : gss_pkg::STATUS_FEW;
                     cnt_in  = '0;
                     rsum_in = '0;
                     tsum_in = '0;
                     rsq_in  = '0;
                     tsq_in  = '0;
                     xsum_in = '0;
                     ovf_in  = 1'b0;
                  end else begin
                     rsp_in.status = gss_pkg::STATUS_OK;
                     step_in       = gss_pkg::ST_SXSY;
                     state_in      = gss_pkg::GSS_ISSUE;
                  end
               end
            end
         end
         gss_pkg::GSS_ISSUE: begin
            state_in = gss_pkg::GSS_WAIT;
         end
         gss_pkg::GSS_WAIT: begin
            if (alu_done) begin
               state_in = gss_pkg::GSS_ISSUE;
               step_in  = gss_pkg::gss_next_step(step_ff);
               case (step_ff)
                  gss_pkg::ST_SXSY: begin
                     p_in  = prod_lo;
                     sv_in = (QW+1)'(rsq_ff) + (QW+1)'(tsq_ff);
                  end
                  gss_pkg::ST_NN: begin
                     t_in = prod_lo;
                  end
                  gss_pkg::ST_K1: begin
                     k1_in = prod_lo;
                     t_in  = t_ff - OW'(cnt_ff);
                  end
                  gss_pkg::ST_K2: begin
                     k2_in = prod_lo;
                     aa_in = (p_ff << gss_pkg::A_SHIFT) + k1_ff;
                  end
                  gss_pkg::ST_SXX: begin
                     sq_in = prod_lo;
                  end
                  gss_pkg::ST_SYY: begin
                     sq_in = sq_ff + prod_lo;
                  end
                  gss_pkg::ST_NV: begin
                     v_in  = prod_lo - sq_ff;
                     bb_in = (sq_ff << gss_pkg::VAR_SHIFT) + k1_ff;
                  end
                  gss_pkg::ST_NXY: begin
                     dneg_in = pxy_diff[OW];
                     dmag_in = pxy_diff[OW] ? p_ff - prod_lo : pxy_diff[OW-1:0];
                     dd_in   = (v_ff << gss_pkg::VAR_SHIFT) + k2_ff;
                  end
                  gss_pkg::ST_DEN: begin
                     den_in = alu_acc[PW-1:0];
                     if (!dneg_ff) begin
                        kmag_in = t9 + k2_ff;
                        neg_in  = 1'b0;
                     end else if (t9 > k2_ff) begin
                        kmag_in = t9 - k2_ff;
                        neg_in  = 1'b1;
                     end else begin
                        kmag_in = k2_ff - t9;
                        neg_in  = 1'b0;
                     end
                  end
                  gss_pkg::ST_NUM: ;
                  gss_pkg::ST_DIV: begin
                     state_in        = gss_pkg::GSS_IDLE;
                     rsp_strobe_in   = 1'b1;
                     rsp_in.ssim_q16 = ssim_val;
                     cnt_in  = '0;
                     rsum_in = '0;
                     tsum_in = '0;
                     rsq_in  = '0;
                     tsq_in  = '0;
                     xsum_in = '0;
                     ovf_in  = 1'b0;
                  end
                  default: state_in = gss_pkg::GSS_IDLE;
               endcase
            end
         end
         default: state_in = gss_pkg::GSS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= gss_pkg::GSS_IDLE;
         step_ff       <= gss_pkg::ST_SXSY;
         cnt_ff        <= '0;
         rsum_ff       <= '0;
         tsum_ff       <= '0;
         rsq_ff        <= '0;
         tsq_ff        <= '0;
         xsum_ff       <= '0;
         ovf_ff        <= 1'b0;
         c1_ff         <= gss_pkg::C1_RESET;
         c2_ff         <= gss_pkg::C2_RESET;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         step_ff       <= step_in;
         cnt_ff        <= cnt_in;
         rsum_ff       <= rsum_in;
         tsum_ff       <= tsum_in;
         rsq_ff        <= rsq_in;
         tsq_ff        <= tsq_in;
         xsum_ff       <= xsum_in;
         ovf_ff        <= ovf_in;
         c1_ff         <= c1_in;
         c2_ff         <= c2_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      sv_ff   <= sv_in;
      p_ff    <= p_in;
      t_ff    <= t_in;
      k1_ff   <= k1_in;
      k2_ff   <= k2_in;
      aa_ff   <= aa_in;
      sq_ff   <= sq_in;
      v_ff    <= v_in;
      bb_ff   <= bb_in;
      dd_ff   <= dd_in;
      dmag_ff <= dmag_in;
      dneg_ff <= dneg_in;
      kmag_ff <= kmag_in;
      neg_ff  <= neg_in;
      den_ff  <= den_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

### sim/global_ssim_score_core_test.sv
// Self-checking bench for global_ssim_score_core: pixel-pair images in, SSIM scores out,
// each score checked against a wide-integer predictor of the exact SSIM formula.
// Depends on rtl/gss_pkg.sv, rtl/global_ssim_score_core.sv and rtl/gss_alu.sv.
module global_ssim_score_core_test;

   localparam int CLOCK_PERIOD = 20;
   localparam int COUNT_BITS = gss_pkg::PIXEL_COUNT_BITS_DEFAULT;
   localparam logic [gss_pkg::TOTAL_BITS-1:0] COUNT_CAP = 21'd1 << COUNT_BITS;
   localparam longint unsigned CYCLE_LIMIT = 64'd8_000_000;
   localparam int SCORE_LATENCY = 10 * COUNT_BITS + 160;
   localparam int PHASE_ITEMS = 390;

   typedef enum int {
      PIX_UNIFORM,
      PIX_FLAT,
      PIX_SAME,
      PIX_MIRROR,
      PIX_NEAR,
      PIX_RAILS
   } pixel_style_type;

   logic clock = 1'b0;
   logic reset;
   logic start;
   logic busy;
   gss_pkg::gss_req_type req_data;
   logic rsp_strobe;
   gss_pkg::gss_rsp_type rsp_data;
   logic csr_valid;
   logic csr_ready;
   logic [gss_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [gss_pkg::CFG_BITS-1:0] csr_data;

   logic [gss_pkg::CFG_BITS-1:0] c1_setting = gss_pkg::C1_RESET;
   logic [gss_pkg::CFG_BITS-1:0] c2_setting = gss_pkg::C2_RESET;
   logic [gss_pkg::TOTAL_BITS-1:0] pair_tally = '0;
   logic [27:0] ref_total = '0;
   logic [27:0] test_total = '0;
   logic [35:0] ref_energy = '0;
   logic [35:0] test_energy = '0;
   logic [35:0] cross_energy = '0;
   logic count_capped = 1'b0;

   gss_pkg::gss_rsp_type pending_scores[$];
   gss_pkg::gss_rsp_type score_beat;
   int mismatch_count = 0;
   int beats_checked = 0;
   int items_sent = 0;
   int sender_idle_pct = 0;
   longint unsigned cycle_count = 0;

   global_ssim_score_core #(
      .PIXEL_COUNT_BITS(COUNT_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[global_ssim_score_core] ERROR");
         $finish;
      end
   end

   task automatic report_mismatch(input string field, input longint got, input longint want);
      $display("mismatch on %s: got %0d, expected %0d (beat %0d)", field, got, want,
               beats_checked);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (pending_scores.size() == 0) begin
            report_mismatch("unexpected beat", rsp_data.pixel_total, 0);
         end else begin
            score_beat = pending_scores.pop_front();
            if (rsp_data.ssim_q16 !== score_beat.ssim_q16)
               report_mismatch("ssim_q16", rsp_data.ssim_q16, score_beat.ssim_q16);
            if (rsp_data.pixel_total !== score_beat.pixel_total)
               report_mismatch("pixel_total", rsp_data.pixel_total, score_beat.pixel_total);
            if (rsp_data.status !== score_beat.status)
               report_mismatch("status", rsp_data.status, score_beat.status);
         end
         beats_checked++;
      end
   end

   // exact SSIM = A*K / (B*D), scaled by 2^16 and rounded half away from zero
   function automatic logic signed [gss_pkg::SSIM_BITS-1:0] ssim_from_sums();
      logic [255:0] n, sx, sy, sxx, syy, sxy, c1, c2;
      logic [255:0] sxsy, k1, k2, num_a, den_b, den_d, pxy, t, kmag, num, den, q, rem;
      logic negative;
      n = 256'(pair_tally);
      sx = 256'(ref_total);
      sy = 256'(test_total);
      sxx = 256'(ref_energy);
      syy = 256'(test_energy);
      sxy = 256'(cross_energy);
      c1 = 256'(c1_setting);
      c2 = 256'(c2_setting);
      negative = 1'b0;
      sxsy = sx * sy;
      k1 = c1 * n * n;
      k2 = c2 * n * (n - 1);
      num_a = 512 * sxsy + k1;
      den_b = 256 * (sx * sx + sy * sy) + k1;
      den_d = 256 * ((n * sxx - sx * sx) + (n * syy - sy * sy)) + k2;
      pxy = n * sxy;
      if (pxy >= sxsy) begin
         kmag = 512 * (pxy - sxsy) + k2;
      end else begin
         t = 512 * (sxsy - pxy);
         if (t > k2) begin
            kmag = t - k2;
            negative = 1'b1;
         end else begin
            kmag = k2 - t;
         end
      end
      den = den_b * den_d;
      if (den == 0) return gss_pkg::SSIM_ONE;
      num = (num_a * kmag) << 16;
      q = num / den;
      rem = num % den;
      if ((rem << 1) >= den) q = q + 1;
      if (q > 256'd65536) q = 256'd65536;
      return negative ? -q[gss_pkg::SSIM_BITS-1:0] : q[gss_pkg::SSIM_BITS-1:0];
   endfunction

   task automatic absorb_pair(input logic [7:0] ref_px, test_px, input logic last);
      gss_pkg::gss_rsp_type expected;
      if (pair_tally < COUNT_CAP) begin
         pair_tally = pair_tally + gss_pkg::TOTAL_BITS'(1);
         ref_total += 28'(ref_px);
         test_total += 28'(test_px);
         ref_energy += 36'(ref_px) * 36'(ref_px);
         test_energy += 36'(test_px) * 36'(test_px);
         cross_energy += 36'(ref_px) * 36'(test_px);
      end else begin
         count_capped = 1'b1;
      end
      if (last) begin
         expected.pixel_total = pair_tally;
         expected.ssim_q16 = '0;
         if (count_capped) begin
            expected.status = gss_pkg::STATUS_OVERFLOW;
         end else if (pair_tally < 2) begin
            expected.status = gss_pkg::STATUS_FEW;
         end else begin
            expected.status = gss_pkg::STATUS_OK;
            expected.ssim_q16 = ssim_from_sums();
         end
         pending_scores = {pending_scores, expected};
         pair_tally = '0;
         ref_total = '0;
         test_total = '0;
         ref_energy = '0;
         test_energy = '0;
         cross_energy = '0;
         count_capped = 1'b0;
      end
   endtask

   function automatic logic [7:0] random_byte();
      logic [31:0] w;
      w = $urandom;
      return w[7:0];
   endfunction

   task automatic send_pair(input logic [7:0] ref_px, test_px, input logic last);
      gss_pkg::gss_req_type beat;
      logic [31:0] noise;
      beat.ref_pixel = ref_px;
      beat.test_pixel = test_px;
      beat.last_pixel = last;
      req_data <= beat;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      absorb_pair(ref_px, test_px, last);
      items_sent++;
      while ($urandom_range(99) < sender_idle_pct) begin
         noise = $urandom;
         start <= 1'b0;
         req_data <= noise[$bits(gss_pkg::gss_req_type)-1:0];
         @(posedge clock);
      end
   endtask

   // hold start low and wait out every pending score
   task automatic settle_block();
      start <= 1'b0;
      while (pending_scores.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_stabilizer(input logic [gss_pkg::CSR_INDEX_BITS-1:0] index,
                                   input logic [gss_pkg::CFG_BITS-1:0] value);
      csr_index <= index;
      csr_data <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (index == gss_pkg::CSR_C1) c1_setting = value;
      else c2_setting = value;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_stabilizers(input logic [gss_pkg::CFG_BITS-1:0] c1, c2);
      settle_block();
      write_stabilizer(gss_pkg::CSR_C1, c1);
      write_stabilizer(gss_pkg::CSR_C2, c2);
   endtask

   function automatic logic [gss_pkg::CFG_BITS-1:0] pick_stabilizer(
      input logic [gss_pkg::CFG_BITS-1:0] dflt);
      logic [31:0] w;
      w = $urandom;
      case ($urandom_range(4))
         0: return '0;
         1: return '1;
         2: return dflt;
         3: return {8'd0, w[7:0]};
         default: return w[15:0];
      endcase
   endfunction

   function automatic int pick_length();
      int roll;
      roll = $urandom_range(99);
      if (roll < 10) return 1;
      if (roll < 20) return 2;
      if (roll < 90) return $urandom_range(24, 3);
      return $urandom_range(80, 25);
   endfunction

   task automatic send_image(input int length, input pixel_style_type style);
      logic [7:0] base_ref, base_test, ref_px, test_px;
      logic [31:0] w;
      int shifted;
      base_ref = random_byte();
      base_test = random_byte();
      for (int i = 0; i < length; i++) begin
         w = $urandom;
         ref_px = w[7:0];
         test_px = w[15:8];
         case (style)
            PIX_FLAT: begin
               ref_px = base_ref;
               test_px = base_test;
            end
            PIX_SAME: test_px = ref_px;
            PIX_MIRROR: test_px = ~ref_px;
            PIX_NEAR: begin
               shifted = int'(ref_px) + int'($urandom_range(8)) - 4;
               if (shifted < 0) shifted = 0;
               if (shifted > 255) shifted = 255;
               test_px = shifted[7:0];
            end
            PIX_RAILS: begin
               ref_px = w[16] ? 8'hFF : 8'h00;
               test_px = w[17] ? 8'hFF : 8'h00;
            end
            default: ;
         endcase
         send_pair(ref_px, test_px, i == length - 1);
      end
   endtask

   task automatic test_default_stabilizers();
      send_pair(8'd0, 8'd0, 1'b1);
      send_pair(8'd255, 8'd255, 1'b0);
      send_pair(8'd0, 8'd0, 1'b1);
      send_pair(8'd0, 8'd255, 1'b0);
      send_pair(8'd255, 8'd0, 1'b1);
      send_pair(8'd255, 8'd255, 1'b0);
      send_pair(8'd255, 8'd255, 1'b1);
      send_pair(8'd37, 8'd200, 1'b0);
      send_pair(8'd128, 8'd1, 1'b0);
      send_pair(8'd254, 8'd99, 1'b1);
   endtask

   // zero stabilizers make the denominator vanish on flat images
   task automatic test_zero_stabilizers();
      set_stabilizers('0, '0);
      send_pair(8'd0, 8'd0, 1'b0);
      send_pair(8'd0, 8'd0, 1'b1);
      send_pair(8'd100, 8'd170, 1'b0);
      send_pair(8'd100, 8'd170, 1'b1);
      send_pair(8'd0, 8'd0, 1'b0);
      send_pair(8'd0, 8'd255, 1'b1);
   endtask

   task automatic test_full_stabilizers();
      set_stabilizers('1, '1);
      send_pair(8'd0, 8'd0, 1'b0);
      send_pair(8'd255, 8'd255, 1'b1);
      send_pair(8'd255, 8'd0, 1'b0);
      send_pair(8'd0, 8'd255, 1'b1);
   endtask

   task automatic test_random_images();
      int quota;
      for (int phase = 0; phase < 4; phase++) begin
         set_stabilizers(pick_stabilizer(gss_pkg::C1_RESET),
                         pick_stabilizer(gss_pkg::C2_RESET));
         case (phase)
            1: sender_idle_pct = 54;
            3: sender_idle_pct = 35;
            default: sender_idle_pct = 0;
         endcase
         quota = items_sent + PHASE_ITEMS;
         while (items_sent < quota)
            send_image(pick_length(), pixel_style_type'($urandom_range(5)));
      end
      sender_idle_pct = 0;
   endtask

   task automatic test_long_images();
      set_stabilizers(pick_stabilizer(gss_pkg::C1_RESET),
                      pick_stabilizer(gss_pkg::C2_RESET));
      send_image(40, PIX_NEAR);
      send_image(24, PIX_MIRROR);
   endtask

   initial begin
      reset <= 1'b1;
      start <= 1'b0;
      req_data <= '0;
      csr_valid <= 1'b0;
      csr_index <= gss_pkg::CSR_C1;
      csr_data <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_default_stabilizers();
      test_zero_stabilizers();
      test_full_stabilizers();
      test_random_images();
      test_long_images();
      settle_block();
      repeat (SCORE_LATENCY) @(posedge clock);
      if (mismatch_count == 0 && pending_scores.size() == 0) begin
         $display("[global_ssim_score_core] OK");
      end else begin
         $display("[global_ssim_score_core] ERROR");
      end
      $finish;
   end

endmodule
